// File: rtl/baro_pressure_temperature_compensation_unit_defines.svh
// Assertion macros for the barometer compensation unit.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef BARO_PRESSURE_TEMPERATURE_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_PRESSURE_TEMPERATURE_COMPENSATION_UNIT_DEFINES_SVH

// checked only out of reset
`define BPTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define BPTC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/bptc_pkg.sv
// Shared types, constants and 64-bit wrapping multiply helpers for the
// barometer compensation unit. No dependencies.
`timescale 1ns / 1ps

package bptc_pkg;

  localparam int CFG_IDX_W   = 2;
  localparam int CAL_W       = 48;
  localparam int RAW_W       = 20;
  localparam int TEMP_W      = 20;
  localparam int PRESS_W     = 32;
  localparam int DIV_W       = 64;
  localparam int DEN_W       = 31;
  localparam int PRE_STAGES  = 14;
  localparam int POST_STAGES = 6;
  localparam int NST         = PRE_STAGES + DIV_W + POST_STAGES;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAL_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAL_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CAL_C = 2'd3;

  localparam logic [63:0] FINE_OFFSET    = 64'd128000;
  localparam logic [20:0] RAW_FULL_SCALE = 21'd1048576;
  localparam logic [63:0] DIV_SCALE      = 64'd3125;
  localparam logic [63:0] PRESS_BIAS     = 64'h0000_8000_0000_0000;
  localparam logic [PRESS_W-1:0] PRESS_MAX = 32'hFFFF_FFFF;

  typedef logic [63:0] w64_t;

  // partial products of a 64x64 product mod 2^64
  typedef struct packed {
    logic [63:0] lo;
    logic [31:0] x;
  } mpart_t;

  // travels with an item through the divider
  typedef struct packed {
    logic [TEMP_W-1:0] tcent;
    logic              ok;
    logic              neg;
  } dtag_t;

  function automatic mpart_t mul_part(input logic [63:0] u, input logic [63:0] v);
    logic [63:0] pl;
    logic [63:0] c1;
    logic [63:0] c2;
    mpart_t      r;
    pl   = u[31:0] * v[31:0];
    c1   = u[31:0] * v[63:32];
    c2   = u[63:32] * v[31:0];
    r.lo = pl;
    r.x  = c1[31:0] + c2[31:0];
    return r;
  endfunction

  function automatic w64_t mul_join(input mpart_t p);
    return p.lo + {p.x, 32'd0};
  endfunction

  function automatic w64_t sext16(input logic [15:0] f);
    return {{48{f[15]}}, f};
  endfunction

endpackage

// File: rtl/baro_pressure_temperature_compensation_unit.sv
// Top level of the barometer compensation unit: config registers, temperature
// and pressure pipeline. Depends on bptc_pkg, bptc_div and the defines header.
//
//  port group  direction  handshake           payload
//  in_*        input      in_valid/in_stall   raw_temperature, raw_pressure
//  out_*       output     out_valid/out_stall temperature_centi, pressure_q24_8,
//                                             pressure_valid
//  cfg_*       input      cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// One item enters per cycle while in_stall is low; the pipeline is the 64-stage
// divider plus 14 stages before it and 6 after it.
// All stages move together; out_stall with a waiting result freezes the whole
// pipeline and raises in_stall in the same cycle.
// rst_n (synchronous) empties the pipeline and clears the calibration words.
// cfg_ready is always high.
`timescale 1ns / 1ps
`include "baro_pressure_temperature_compensation_unit_defines.svh"

module baro_pressure_temperature_compensation_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bptc_pkg::RAW_W-1:0]          in_raw_temperature,
  input  logic [bptc_pkg::RAW_W-1:0]          in_raw_pressure,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bptc_pkg::TEMP_W-1:0]  out_temperature_centi,
  output logic [bptc_pkg::PRESS_W-1:0]        out_pressure_q24_8,
  output logic                                out_pressure_valid,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bptc_pkg::CAL_W-1:0]          cfg_wdata
);

  localparam int NST = bptc_pkg::NST;

  // ---------------------------------------------------------------- config
  logic [bptc_pkg::CAL_W-1:0] cal_t_r, cal_a_r, cal_b_r, cal_c_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_t_r <= '0;
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bptc_pkg::CFG_TEMP_CAL:    cal_t_r <= cfg_wdata;
        bptc_pkg::CFG_PRESS_CAL_A: cal_a_r <= cfg_wdata;
        bptc_pkg::CFG_PRESS_CAL_B: cal_b_r <= cfg_wdata;
        bptc_pkg::CFG_PRESS_CAL_C: cal_c_r <= cfg_wdata;
      endcase
    end
  end

  logic [15:0]        t1_w;
  logic signed [15:0] t2_w, t3_w;
  bptc_pkg::w64_t     p1_w, p2_w, p3_w, p4_w, p5_w, p6_w, p7_w, p8_w, p9_w;

  assign t1_w = cal_t_r[15:0];
  assign t2_w = $signed(cal_t_r[31:16]);
  assign t3_w = $signed(cal_t_r[47:32]);
  assign p1_w = {48'd0, cal_a_r[15:0]};
  assign p2_w = bptc_pkg::sext16(cal_a_r[31:16]);
  assign p3_w = bptc_pkg::sext16(cal_a_r[47:32]);
  assign p4_w = bptc_pkg::sext16(cal_b_r[15:0]);
  assign p5_w = bptc_pkg::sext16(cal_b_r[31:16]);
  assign p6_w = bptc_pkg::sext16(cal_b_r[47:32]);
  assign p7_w = bptc_pkg::sext16(cal_c_r[15:0]);
  assign p8_w = bptc_pkg::sext16(cal_c_r[31:16]);
  assign p9_w = bptc_pkg::sext16(cal_c_r[47:32]);

  // ---------------------------------------------------------------- control
  logic [NST-1:0] vld_r;
  logic           adv;

  assign adv       = !(vld_r[NST-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------- datapath
  logic signed [18:0] d1_r;
  logic signed [17:0] d2_r;
  logic signed [34:0] lin_p_r;
  logic signed [35:0] sq_p_r;
  logic signed [23:0] lin_r;
  logic signed [39:0] sqm_r;
  logic signed [25:0] fine_r;
  bptc_pkg::w64_t     a_r;
  logic [bptc_pkg::RAW_W-1:0]  rp_r [1:10];
  logic [bptc_pkg::TEMP_W-1:0] tc_r [5:13];

  bptc_pkg::mpart_t mp_aa_r, mp_a5_r, mp_a2_r, mp_aa6_r, mp_aa3_r, mp_x1_r, mp_n_r;
  bptc_pkg::w64_t   aa_r, ap5_r, ap2_r, ap5_8_r, ap2_8_r, aap6_r, aap3_r, ap5_9_r, ap2_9_r;
  bptc_pkg::w64_t   b_r, x_r, num0_r, xp1_r, den_r, num_r;

  logic [bptc_pkg::DIV_W-1:0] nmag_r;
  logic [bptc_pkg::DEN_W-1:0] dmag_r;
  bptc_pkg::dtag_t            tag14_r;

  // stage-local combinational values
  logic signed [28:0] t5_w;
  logic [20:0]        qr_w;
  bptc_pkg::w64_t     den_neg_w;

  assign t5_w = {fine_r[25], fine_r, 2'b00} + {{3{fine_r[25]}}, fine_r} + 29'sd128;
  assign qr_w = bptc_pkg::RAW_FULL_SCALE - {1'b0, rp_r[10]};
  assign den_neg_w = -den_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      // S1: temperature differences
      d1_r <= $signed({2'b00, in_raw_temperature[19:3]} - {2'b00, t1_w, 1'b0});
      d2_r <= $signed({2'b00, in_raw_temperature[19:4]} - {2'b00, t1_w});
      rp_r[1] <= in_raw_pressure;
      for (int k = 2; k <= 10; k++) rp_r[k] <= rp_r[k-1];
      // S2
      lin_p_r <= d1_r * t2_w;
      sq_p_r  <= d2_r * d2_r;
      // S3
      lin_r <= lin_p_r[34:11];
      sqm_r <= $signed(sq_p_r[35:12]) * t3_w;
      // S4: fine temperature
      fine_r <= {{2{lin_r[23]}}, lin_r} + sqm_r[39:14];
      // S5: hundredths of a degree fit the output width, no clamp needed
      tc_r[5] <= t5_w[27:8];
      a_r     <= {{38{fine_r[25]}}, fine_r} - bptc_pkg::FINE_OFFSET;
      for (int k = 6; k <= 13; k++) tc_r[k] <= tc_r[k-1];
      // S6
      mp_aa_r <= bptc_pkg::mul_part(a_r, a_r);
      mp_a5_r <= bptc_pkg::mul_part(a_r, p5_w);
      mp_a2_r <= bptc_pkg::mul_part(a_r, p2_w);
      // S7
      aa_r  <= bptc_pkg::mul_join(mp_aa_r);
      ap5_r <= bptc_pkg::mul_join(mp_a5_r);
      ap2_r <= bptc_pkg::mul_join(mp_a2_r);
      // S8
      mp_aa6_r <= bptc_pkg::mul_part(aa_r, p6_w);
      mp_aa3_r <= bptc_pkg::mul_part(aa_r, p3_w);
      ap5_8_r  <= ap5_r;
      ap2_8_r  <= ap2_r;
      // S9
      aap6_r  <= bptc_pkg::mul_join(mp_aa6_r);
      aap3_r  <= bptc_pkg::mul_join(mp_aa3_r);
      ap5_9_r <= ap5_8_r;
      ap2_9_r <= ap2_8_r;
      // S10: offset and scale terms
      b_r <= aap6_r + {ap5_9_r[46:0], 17'd0} + {p4_w[28:0], 35'd0};
      x_r <= bptc_pkg::PRESS_BIAS + bptc_pkg::w64_t'($signed(aap3_r) >>> 8)
             + {ap2_9_r[51:0], 12'd0};
      // S11
      mp_x1_r <= bptc_pkg::mul_part(x_r, p1_w);
      num0_r  <= {12'd0, qr_w, 31'd0} - b_r;
      // S12
      xp1_r  <= bptc_pkg::mul_join(mp_x1_r);
      mp_n_r <= bptc_pkg::mul_part(num0_r, bptc_pkg::DIV_SCALE);
      // S13
      den_r <= bptc_pkg::w64_t'($signed(xp1_r) >>> 33);
      num_r <= bptc_pkg::mul_join(mp_n_r);
      // S14: signs out, magnitudes into the divider
      nmag_r        <= num_r[63] ? -num_r : num_r;
      dmag_r        <= den_r[63] ? den_neg_w[bptc_pkg::DEN_W-1:0]
                                 : den_r[bptc_pkg::DEN_W-1:0];
      tag14_r.tcent <= tc_r[13];
      tag14_r.ok    <= (den_r != '0);
      tag14_r.neg   <= num_r[63] ^ den_r[63];
    end
  end

  logic [bptc_pkg::DIV_W-1:0] quo_w;
  bptc_pkg::dtag_t            tagd_w;

  bptc_div u_div (
    .clk   (clk),
    .en    (adv),
    .num   (nmag_r),
    .den   (dmag_r),
    .tag_i (tag14_r),
    .quo   (quo_w),
    .tag_o (tagd_w)
  );

  // ---------------------------------------------------------------- correction
  bptc_pkg::w64_t   q1_r, q2_r, q3_r, q4_r, q5_r, p9h_r, p8q_r, e2_r, e2_5_r, e1_r;
  bptc_pkg::mpart_t mp_9h_r, mp_8q_r, mp_e1_r;
  bptc_pkg::dtag_t  tg_r [1:5];
  bptc_pkg::w64_t   hi1_w, hi3_w, s_w;

  logic signed [bptc_pkg::TEMP_W-1:0] out_temperature_centi_r;
  logic [bptc_pkg::PRESS_W-1:0]       out_pressure_q24_8_r;
  logic                               out_pressure_valid_r;

  assign hi1_w = bptc_pkg::w64_t'($signed(q1_r) >>> 13);
  assign hi3_w = bptc_pkg::w64_t'($signed(q3_r) >>> 13);
  assign s_w   = bptc_pkg::w64_t'($signed(q5_r + e1_r + e2_5_r) >>> 8) + {p7_w[59:0], 4'd0};

  always_ff @(posedge clk) begin
    if (adv) begin
      // R1: restore quotient sign (truncation toward zero)
      q1_r   <= tagd_w.neg ? -quo_w : quo_w;
      tg_r[1] <= tagd_w;
      for (int k = 2; k <= 5; k++) tg_r[k] <= tg_r[k-1];
      // R2
      mp_9h_r <= bptc_pkg::mul_part(p9_w, hi1_w);
      mp_8q_r <= bptc_pkg::mul_part(p8_w, q1_r);
      q2_r    <= q1_r;
      // R3
      p9h_r <= bptc_pkg::mul_join(mp_9h_r);
      p8q_r <= bptc_pkg::mul_join(mp_8q_r);
      q3_r  <= q2_r;
      // R4
      mp_e1_r <= bptc_pkg::mul_part(p9h_r, hi3_w);
      e2_r    <= bptc_pkg::w64_t'($signed(p8q_r) >>> 19);
      q4_r    <= q3_r;
      // R5
      e1_r   <= bptc_pkg::w64_t'($signed(bptc_pkg::mul_join(mp_e1_r)) >>> 25);
      e2_5_r <= e2_r;
      q5_r   <= q4_r;
      // R6: clamp to unsigned 32 bits, zero when the divisor was zero
      out_temperature_centi_r <= tg_r[5].tcent;
      out_pressure_valid_r    <= tg_r[5].ok;
      if (!tg_r[5].ok || s_w[63]) begin
        out_pressure_q24_8_r <= '0;
      end else if (s_w[63:32] != '0) begin
        out_pressure_q24_8_r <= bptc_pkg::PRESS_MAX;
      end else begin
        out_pressure_q24_8_r <= s_w[31:0];
      end
    end
  end

  assign out_temperature_centi = out_temperature_centi_r;
  assign out_pressure_q24_8    = out_pressure_q24_8_r;
  assign out_pressure_valid    = out_pressure_valid_r;

  // ---------------------------------------------------------------- checks
  `BPTC_ASSERT(a_invalid_zero, out_valid && !out_pressure_valid |-> out_pressure_q24_8 == '0, "invalid pressure not zeroed")
  `BPTC_ASSERT(a_stall_freeze, out_valid && out_stall |=> $stable(vld_r), "pipeline moved while stalled")
  `BPTC_ASSERT_RST(a_reset_flush, !rst_n |=> vld_r == '0, "pipeline not emptied by reset")

endmodule

// File: rtl/bptc_div.sv
// Pipelined unsigned 64 / 31 bit restoring divider, one quotient bit per stage.
// Depends on bptc_pkg for widths and the tag type.
`timescale 1ns / 1ps

module bptc_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bptc_pkg::DIV_W-1:0]  num,
  input  logic [bptc_pkg::DEN_W-1:0]  den,
  input  bptc_pkg::dtag_t             tag_i,
  output logic [bptc_pkg::DIV_W-1:0]  quo,
  output bptc_pkg::dtag_t             tag_o
);

  localparam int NW = bptc_pkg::DIV_W;
  localparam int DW = bptc_pkg::DEN_W;

  logic [DW-1:0]   rem_r [0:NW-1];
  logic [NW-1:0]   nq_r  [0:NW-1];  // dividend bits leave at the top, quotient enters below
  logic [DW-1:0]   d_r   [0:NW-1];
  bptc_pkg::dtag_t t_r   [0:NW-1];

  for (genvar k = 0; k < NW; k++) begin : g_st
    logic [DW-1:0]   rem_c;
    logic [NW-1:0]   nq_c;
    logic [DW-1:0]   d_c;
    bptc_pkg::dtag_t t_c;
    logic [DW:0]     trial;
    logic [DW+1:0]   diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign rem_c = '0;
      assign nq_c  = num;
      assign d_c   = den;
      assign t_c   = tag_i;
    end else begin : g_next
      assign rem_c = rem_r[k-1];
      assign nq_c  = nq_r[k-1];
      assign d_c   = d_r[k-1];
      assign t_c   = t_r[k-1];
    end

    assign trial = {rem_c, nq_c[NW-1]};
    assign diff  = {1'b0, trial} - {2'b00, d_c};
    assign ge    = !diff[DW+1];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        nq_r[k]  <= {nq_c[NW-2:0], ge};
        d_r[k]   <= d_c;
        t_r[k]   <= t_c;
      end
    end
  end

  assign quo   = nq_r[NW-1];
  assign tag_o = t_r[NW-1];

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the barometer compensation unit.
// Depends on bptc_pkg and the top level; scoreboard class plus driver tasks.
`timescale 1ns / 1ps

module tb_top;

  typedef logic [bptc_pkg::CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [bptc_pkg::CAL_W-1:0]     cal_t;
  typedef logic [bptc_pkg::RAW_W-1:0]     raw_t;

  typedef struct packed {
    logic signed [bptc_pkg::TEMP_W-1:0] tcent;
    logic [bptc_pkg::PRESS_W-1:0]       press;
    logic                               pvalid;
  } comp_res_t;

  class comp_scoreboard;
    cal_t      cal [4];
    comp_res_t pending [$];
    int        errors;

    function new();
      errors = 0;
      foreach (cal[i]) cal[i] = '0;
    endfunction

    function bptc_pkg::w64_t asr(bptc_pkg::w64_t x, int n);
      return bptc_pkg::w64_t'($signed(x) >>> n);
    endfunction

    function bptc_pkg::w64_t s16(cal_t w, int pos);
      return {{48{w[pos+15]}}, w[pos+:16]};
    endfunction

    function comp_res_t compensate(raw_t rt, raw_t rp);
      bptc_pkg::w64_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      bptc_pkg::w64_t d1, lin, d2, sq, fine, a, b, q, hi, e1, e2, num, den, mq;
      longint signed st;
      comp_res_t r;
      t1 = {48'd0, cal[0][15:0]}; t2 = s16(cal[0], 16); t3 = s16(cal[0], 32);
      p1 = {48'd0, cal[1][15:0]}; p2 = s16(cal[1], 16); p3 = s16(cal[1], 32);
      p4 = s16(cal[2], 0); p5 = s16(cal[2], 16); p6 = s16(cal[2], 32);
      p7 = s16(cal[3], 0); p8 = s16(cal[3], 16); p9 = s16(cal[3], 32);
      d1 = bptc_pkg::w64_t'(rt >> 3) - (t1 << 1);
      lin = asr(d1 * t2, 11);
      d2 = bptc_pkg::w64_t'(rt >> 4) - t1;
      sq = asr(asr(d2 * d2, 12) * t3, 14);
      fine = lin + sq;
      st = $signed(asr(fine * 64'd5 + 64'd128, 8));
      if (st > 524287) st = 524287;
      if (st < -524288) st = -524288;
      r.tcent = st[bptc_pkg::TEMP_W-1:0];
      a = fine - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = asr(a * a * p3, 8) + ((a * p2) << 12);
      a = asr(((64'd1 << 47) + a) * p1, 33);
      r.press = '0;
      r.pvalid = 1'b0;
      if (a != 0) begin
        q = 64'd1048576 - bptc_pkg::w64_t'(rp);
        num = ((q << 31) - b) * 64'd3125;
        den = a;
        mq = (num[63] ? -num : num) / (den[63] ? -den : den);
        q = (num[63] != den[63]) ? -mq : mq;
        hi = asr(q, 13);
        e1 = asr(p9 * hi * hi, 25);
        e2 = asr(p8 * q, 19);
        q = asr(q + e1 + e2, 8) + (p7 << 4);
        st = $signed(q);
        if (st < 0) r.press = '0;
        else if (q > 64'hFFFF_FFFF) r.press = bptc_pkg::PRESS_MAX;
        else r.press = q[31:0];
        r.pvalid = 1'b1;
      end
      return r;
    endfunction

    function void note_input(raw_t rt, raw_t rp);
      pending.push_back(compensate(rt, rp));
    endfunction

    function void check_result(comp_res_t got);
      comp_res_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.tcent !== exp_r.tcent) begin
        $display("%0t: temperature_centi expected %0d actual %0d", $time,
                 exp_r.tcent, got.tcent);
        errors++;
      end
      if (got.press !== exp_r.press) begin
        $display("%0t: pressure_q24_8 expected %h actual %h", $time,
                 exp_r.press, got.press);
        errors++;
      end
      if (got.pvalid !== exp_r.pvalid) begin
        $display("%0t: pressure_valid expected %b actual %b", $time,
                 exp_r.pvalid, got.pvalid);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY = 84;
  localparam int WATCHDOG = 20000;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  raw_t in_raw_temperature = '0, in_raw_pressure = '0;
  logic out_valid, out_stall = 0;
  logic signed [bptc_pkg::TEMP_W-1:0] out_temperature_centi;
  logic [bptc_pkg::PRESS_W-1:0] out_pressure_q24_8;
  logic out_pressure_valid;
  logic cfg_valid = 0, cfg_ready;
  cfg_idx_t cfg_index = '0;
  cal_t cfg_wdata = '0;

  comp_scoreboard sb = new();
  int send_idle_pct = 0, stall_pct = 0, idle_count = 0;

  always #2 clk = ~clk;

  baro_pressure_temperature_compensation_unit dut (.*);

  // monitor: sample at rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_raw_temperature, in_raw_pressure);
      if (out_valid && !out_stall)
        sb.check_result('{out_temperature_centi, out_pressure_q24_8, out_pressure_valid});
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_count <= 0;
      else
        idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // cfg_valid drops after each write and stays low before the next one, one update per edge
  task automatic write_cal(cfg_idx_t idx, cal_t val);
    cfg_valid <= 1; cfg_index <= idx; cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.cal[idx] = val;
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic send_sample(raw_t rt, raw_t rp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_raw_temperature <= rt; in_raw_pressure <= rp;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // calibration near typical sensor values, perturbed
  task automatic typical_cal();
    logic [15:0] t1, p1;
    t1 = 16'd27504 + 16'($urandom_range(4000)) - 16'd2000;
    p1 = 16'd36477 + 16'($urandom_range(4000)) - 16'd2000;
    write_cal(bptc_pkg::CFG_TEMP_CAL, {16'($signed(-16'sd1000) + $urandom_range(2000)),
                                       16'd26435 + 16'($urandom_range(2000)), t1});
    write_cal(bptc_pkg::CFG_PRESS_CAL_A, {16'd3024 + 16'($urandom_range(200)),
                                          16'(-16'sd10685 + $urandom_range(400)), p1});
    write_cal(bptc_pkg::CFG_PRESS_CAL_B, {16'(-16'sd7) + 16'($urandom_range(14)),
                                          16'(-16'sd140 + $urandom_range(280)),
                                          16'd2855 + 16'($urandom_range(400))});
    write_cal(bptc_pkg::CFG_PRESS_CAL_C, {16'd6000 + 16'($urandom_range(200)),
                                          16'(-16'sd14600 + $urandom_range(400)),
                                          16'd15500 + 16'($urandom_range(100))});
  endtask

  task automatic random_cal();
    for (int i = 0; i < 4; i++)
      write_cal(cfg_idx_t'(i), cal_t'({$urandom, $urandom}));
  endtask

  task automatic random_items(int n);
    for (int i = 0; i < n; i++)
      send_sample(raw_t'($urandom_range(20'hFFFFF)), raw_t'($urandom_range(20'hFFFFF)));
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // zero calibration: divisor is zero
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
    typical_cal();
    send_sample(20'd519888, 20'd415148);
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'd0);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'hAAAAA, 20'h55555);
    drain();
    // extremes of every calibration word
    for (int i = 0; i < 4; i++) write_cal(cfg_idx_t'(i), {bptc_pkg::CAL_W{1'b1}});
    send_sample(20'd0, 20'd0);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'd500000, 20'd400000);
    drain();
    for (int i = 0; i < 4; i++) write_cal(cfg_idx_t'(i), 48'h7FFF_8000_FFFF);
    send_sample(20'd0, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'd0);
    drain();
    for (int i = 0; i < 4; i++) write_cal(cfg_idx_t'(i), 48'h8000_7FFF_0001);
    send_sample(20'd12345, 20'd54321);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 71; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 71; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      typical_cal();
      random_items(150);
      drain();
      random_cal();
      random_items(50);
      drain();
      typical_cal();
      random_items(60);
      drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (LATENCY) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule
